[src/hnps_pkg.sv]
// hnps_pkg: shared types and constants for the held note priority stack.
// No dependencies.
package hnps_pkg;

    localparam int KEY_W           = 7;
    localparam int HELD_W          = 4;
    localparam int DEF_STACK_DEPTH = 8;

    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_UPDATE,
        CM_ROTATE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       press;
        logic       found;
        t_key       key;
    } t_cell_ctrl;

    typedef struct packed {
        logic v1;
        t_key k1;
        logic v2;
        t_key k2;
    } t_rank;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

[src/held_note_priority_stack.sv]
// Each input transfer runs through an update step, a rotation of the cell chain past the
// ranking unit, and a load of the result registers, which waits while the output stalls.
// A new item is taken only once the result of the last one has been loaded;
// the rotation scan through the cell chain sets the time per item.
// Reset clears the held count and control state; slot keys are not cleared.
module held_note_priority_stack #(
    parameter int STACK_DEPTH = hnps_pkg::DEF_STACK_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [hnps_pkg::KEY_W-1:0]   i_note_key,
    input  logic [hnps_pkg::KEY_W-1:0]   i_velocity,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_changed,
    output logic [hnps_pkg::HELD_W-1:0]  o_held_count,
    output logic                         o_newest_valid,
    output logic [hnps_pkg::KEY_W-1:0]   o_newest_key,
    output logic                         o_highest_valid,
    output logic [hnps_pkg::KEY_W-1:0]   o_highest_key,
    output logic                         o_second_valid,
    output logic [hnps_pkg::KEY_W-1:0]   o_second_key
);
    import hnps_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] FULL     = CW'(STACK_DEPTH);
    localparam logic [SW-1:0] LAST_STEP = SW'(STACK_DEPTH - 1);

    t_state r_state;
    t_state n_state;

    t_key            r_key;
    logic            r_press;
    logic            r_changed;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [SW-1:0]   r_step;
    t_key            r_newest;

    logic            r_out_valid;
    logic            r_out_changed;
    logic [CW-1:0]   r_out_count;
    t_key            r_out_newest;
    t_rank           r_out_rank;

    t_cell_ctrl      cell_ctrl;
    t_key            keys  [STACK_DEPTH];
    logic            match [STACK_DEPTH];
    logic            seen  [STACK_DEPTH];
    logic            tail  [STACK_DEPTH];
    logic            found;

    logic            in_xfer;
    logic            out_free;
    logic            rank_clear;
    logic            rank_en;
    logic            load_out;
    t_rank           rank;
    logic [CW+HELD_W-1:0] count_ext;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign found    = tail[0];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        hnps_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_count    (r_count),
            .i_prev_key ((g == 0) ? r_key : keys[(g + STACK_DEPTH - 1) % STACK_DEPTH]),
            .i_next_key (keys[(g + 1) % STACK_DEPTH]),
            .i_seen     ((g == 0) ? 1'b0 : seen[(g + STACK_DEPTH - 1) % STACK_DEPTH]),
            .i_tail     ((g == STACK_DEPTH - 1) ? 1'b0 : tail[(g + 1) % STACK_DEPTH]),
            .o_key      (keys[g]),
            .o_match    (match[g]),
            .o_seen     (seen[g]),
            .o_tail     (tail[g])
        );
    end

    hnps_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (rank_clear),
        .i_en    (rank_en),
        .i_key   (keys[0]),
        .o_rank  (rank)
    );

    always_comb begin
        n_state         = r_state;
        cell_ctrl.mode  = CM_HOLD;
        cell_ctrl.press = r_press;
        cell_ctrl.found = found;
        cell_ctrl.key   = r_key;
        rank_clear      = 1'b0;
        rank_en         = 1'b0;
        load_out        = 1'b0;
        n_count         = r_count;
        o_in_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cell_ctrl.mode = CM_UPDATE;
                rank_clear     = 1'b1;
                if (r_press) begin
                    if (!found && r_count != FULL) begin
                        n_count = r_count + 1'b1;
                    end
                end else if (found) begin
                    n_count = r_count - 1'b1;
                end
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                cell_ctrl.mode = CM_ROTATE;
                rank_en        = CW'(r_step) < r_count;
                if (r_step == LAST_STEP) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_SCAN) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key   <= i_note_key;
            r_press <= (i_velocity != '0);
        end
        if (r_state == ST_UPDATE) begin
            r_changed <= r_press ? !match[0] : found;
        end
        if (r_state == ST_SCAN && r_step == '0) begin
            r_newest <= keys[0];
        end
        if (load_out) begin
            r_out_changed <= r_changed;
            r_out_count   <= r_count;
            r_out_newest  <= (r_count != '0) ? r_newest : '0;
            r_out_rank    <= rank;
        end
    end

    assign count_ext       = (CW + HELD_W)'(r_out_count);
    assign o_out_valid     = r_out_valid;
    assign o_changed       = r_out_changed;
    assign o_held_count    = count_ext[HELD_W-1:0];
    assign o_newest_valid  = (r_out_count != '0);
    assign o_newest_key    = r_out_newest;
    assign o_highest_valid = r_out_rank.v1;
    assign o_highest_key   = r_out_rank.v1 ? r_out_rank.k1 : '0;
    assign o_second_valid  = r_out_rank.v2;
    assign o_second_key    = r_out_rank.v2 ? r_out_rank.k2 : '0;

endmodule

[src/hnps_cell.sv]
// hnps_cell: one slot of the key stack; compares, shifts and rotates with its neighbors.
// Depends on hnps_pkg.
module hnps_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 4
) (
    input  logic                i_clk,
    input  hnps_pkg::t_cell_ctrl i_ctrl,
    input  logic [CW-1:0]       i_count,
    input  hnps_pkg::t_key      i_prev_key,
    input  hnps_pkg::t_key      i_next_key,
    input  logic                i_seen,
    input  logic                i_tail,
    output hnps_pkg::t_key      o_key,
    output logic                o_match,
    output logic                o_seen,
    output logic                o_tail
);
    import hnps_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    t_key r_key;
    t_key n_key;
    logic occ;

    assign occ     = IDX < i_count;
    assign o_match = occ && (r_key == i_ctrl.key);
    assign o_seen  = i_seen | o_match;
    assign o_tail  = i_tail | o_match;
    assign o_key   = r_key;

    always_comb begin
        n_key = r_key;
        unique case (i_ctrl.mode)
            CM_UPDATE: begin
                if (i_ctrl.press) begin
                    if (i_ctrl.found ? o_tail : (IDX <= i_count)) begin
                        n_key = i_prev_key;
                    end
                end else if (o_seen) begin
                    n_key = i_next_key;
                end
            end
            CM_ROTATE: n_key = i_next_key;
            default:   n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

[src/hnps_rank.sv]
// hnps_rank: running highest and second-highest over keys streamed from the cell chain.
// Depends on hnps_pkg.
module hnps_rank (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic           i_en,
    input  hnps_pkg::t_key i_key,
    output hnps_pkg::t_rank o_rank
);
    import hnps_pkg::*;

    t_rank r_rank;
    t_rank n_rank;

    always_comb begin
        n_rank = r_rank;
        priority if (i_clear) begin
            n_rank = '0;
        end else if (i_en) begin
            if (!r_rank.v1 || i_key > r_rank.k1) begin
                n_rank.k2 = r_rank.k1;
                n_rank.v2 = r_rank.v1;
                n_rank.k1 = i_key;
                n_rank.v1 = 1'b1;
            end else if (!r_rank.v2 || i_key > r_rank.k2) begin
                n_rank.k2 = i_key;
                n_rank.v2 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else begin
            r_rank <= n_rank;
        end
    end

    assign o_rank = r_rank;

endmodule

[src/hnps_check.sv]
// hnps_check: port-level assertions for the held note priority stack, bound to the top level.
// Depends on held_note_priority_stack and hnps_pkg.
module hnps_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [hnps_pkg::HELD_W-1:0] o_held_count,
    input logic                        o_newest_valid,
    input logic [hnps_pkg::KEY_W-1:0]  o_newest_key,
    input logic                        o_highest_valid,
    input logic [hnps_pkg::KEY_W-1:0]  o_highest_key,
    input logic                        o_second_valid,
    input logic [hnps_pkg::KEY_W-1:0]  o_second_key
);
    import hnps_pkg::*;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_held_count)
            && $stable(o_highest_key) && $stable(o_newest_key))
        else $error("stalled result changed");

    a_second_below_highest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_second_valid |-> o_highest_valid && (o_second_key < o_highest_key))
        else $error("second key not below highest key");

    a_newest_not_above_highest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_newest_valid |-> o_highest_valid && (o_newest_key <= o_highest_key))
        else $error("newest key above highest key");

    a_empty_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_highest_valid |-> (o_highest_key == '0) && !o_second_valid
            && !o_newest_valid)
        else $error("empty stack reports keys");

endmodule

bind held_note_priority_stack hnps_check u_hnps_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_held_count    (o_held_count),
    .o_newest_valid  (o_newest_valid),
    .o_newest_key    (o_newest_key),
    .o_highest_valid (o_highest_valid),
    .o_highest_key   (o_highest_key),
    .o_second_valid  (o_second_valid),
    .o_second_key    (o_second_key)
);

[tb/held_note_priority_stack_checker.sv]
// Scoreboard for held_note_priority_stack: watches both channels, tracks the held-key
// stack on every input transfer and compares each result transfer field by field.
// Depends on hnps_pkg.
module held_note_priority_stack_checker
    import hnps_pkg::*;
#(
    parameter int STACK_DEPTH = hnps_pkg::DEF_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [KEY_W-1:0]  i_note_key,
    input  logic [KEY_W-1:0]  i_velocity,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_changed,
    input  logic [HELD_W-1:0] i_held_count,
    input  logic              i_newest_valid,
    input  logic [KEY_W-1:0]  i_newest_key,
    input  logic              i_highest_valid,
    input  logic [KEY_W-1:0]  i_highest_key,
    input  logic              i_second_valid,
    input  logic [KEY_W-1:0]  i_second_key,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              changed;
        logic [HELD_W-1:0] held_count;
        logic              newest_valid;
        t_key              newest_key;
        logic              highest_valid;
        t_key              highest_key;
        logic              second_valid;
        t_key              second_key;
    } t_note_report;

    t_key         held_keys [STACK_DEPTH];
    int           held_num;
    t_note_report pending_reports [$];
    int           fail_tally;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_tally   = 0;
        held_num     = 0;
    end

    task automatic apply_note_event(input t_key key, input t_key vel,
                                    output t_note_report rep);
        int   pos;
        int   i;
        logic found;
        logic moved;
        logic v1, v2;
        t_key k1, k2;
        pos   = 0;
        found = 1'b0;
        moved = 1'b0;
        v1    = 1'b0;
        v2    = 1'b0;
        k1    = '0;
        k2    = '0;
        for (i = 0; i < held_num; i++) begin
            if (!found && held_keys[i] == key) begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (vel != 0) begin
            if (!(held_num > 0 && held_keys[0] == key)) begin
                if (found) begin
                    for (i = pos; i > 0; i--) held_keys[i] = held_keys[i-1];
                end else if (held_num >= STACK_DEPTH) begin
                    for (i = STACK_DEPTH - 1; i > 0; i--) held_keys[i] = held_keys[i-1];
                end else begin
                    for (i = held_num; i > 0; i--) held_keys[i] = held_keys[i-1];
                    held_num++;
                end
                held_keys[0] = key;
                moved = 1'b1;
            end
        end else if (found) begin
            held_num--;
            for (i = pos; i < held_num; i++) held_keys[i] = held_keys[i+1];
            moved = 1'b1;
        end
        for (i = 0; i < held_num; i++) begin
            if (!v1 || held_keys[i] > k1) begin
                k2 = k1;
                v2 = v1;
                k1 = held_keys[i];
                v1 = 1'b1;
            end else if (!v2 || held_keys[i] > k2) begin
                k2 = held_keys[i];
                v2 = 1'b1;
            end
        end
        rep.changed       = moved;
        rep.held_count    = held_num[HELD_W-1:0];
        rep.newest_valid  = (held_num > 0);
        rep.newest_key    = (held_num > 0) ? held_keys[0] : '0;
        rep.highest_valid = v1;
        rep.highest_key   = v1 ? k1 : '0;
        rep.second_valid  = v2;
        rep.second_key    = v2 ? k2 : '0;
    endtask

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_tally++;
        end
    endtask

    always @(posedge i_clk) begin
        t_note_report want;
        t_note_report got;
        if (!i_rst_n) begin
            held_num = 0;
            pending_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.changed       = i_changed;
                got.held_count    = i_held_count;
                got.newest_valid  = i_newest_valid;
                got.newest_key    = i_newest_key;
                got.highest_valid = i_highest_valid;
                got.highest_key   = i_highest_key;
                got.second_valid  = i_second_valid;
                got.second_key    = i_second_key;
                if (pending_reports.size() == 0) begin
                    $error("result transfer with no pending note event");
                    fail_tally++;
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("changed", want.changed, got.changed);
                    compare_field("held_count", want.held_count, got.held_count);
                    compare_field("newest_valid", want.newest_valid, got.newest_valid);
                    compare_field("newest_key", want.newest_key, got.newest_key);
                    compare_field("highest_valid", want.highest_valid, got.highest_valid);
                    compare_field("highest_key", want.highest_key, got.highest_key);
                    compare_field("second_valid", want.second_valid, got.second_valid);
                    compare_field("second_key", want.second_key, got.second_key);
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_note_event(i_note_key, i_velocity, want);
                pending_reports.push_back(want);
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= pending_reports.size();
    end

endmodule

[tb/tb_held_note_priority_stack.sv]
// Top of the held_note_priority_stack bench: clock, reset, note-event stimulus with
// random gaps and result back-pressure; verdict from the checker's failure and pending counts.
// Depends on hnps_pkg, held_note_priority_stack and held_note_priority_stack_checker.
module tb_held_note_priority_stack;
    timeunit 1ns;
    timeprecision 1ps;
    import hnps_pkg::*;

    localparam int DEPTH        = hnps_pkg::DEF_STACK_DEPTH;
    localparam int RANDOM_ITEMS = 1830;
    localparam int SETTLE       = DEPTH + 3 + 16;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              in_valid   = 1'b0;
    logic              out_ready  = 1'b0;
    t_key              note_key   = '0;
    t_key              velocity   = '0;
    logic              no_idle    = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_changed;
    logic [HELD_W-1:0] o_held_count;
    logic              o_newest_valid;
    t_key              o_newest_key;
    logic              o_highest_valid;
    t_key              o_highest_key;
    logic              o_second_valid;
    t_key              o_second_key;
    int                fail_count;
    int                pending;

    always #2 i_clk = ~i_clk;

    held_note_priority_stack #(.STACK_DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_note_key      (note_key),
        .i_velocity      (velocity),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_changed       (o_changed),
        .o_held_count    (o_held_count),
        .o_newest_valid  (o_newest_valid),
        .o_newest_key    (o_newest_key),
        .o_highest_valid (o_highest_valid),
        .o_highest_key   (o_highest_key),
        .o_second_valid  (o_second_valid),
        .o_second_key    (o_second_key)
    );

    held_note_priority_stack_checker #(.STACK_DEPTH(DEPTH)) scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (o_in_ready),
        .i_note_key      (note_key),
        .i_velocity      (velocity),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .i_changed       (o_changed),
        .i_held_count    (o_held_count),
        .i_newest_valid  (o_newest_valid),
        .i_newest_key    (o_newest_key),
        .i_highest_valid (o_highest_valid),
        .i_highest_key   (o_highest_key),
        .i_second_valid  (o_second_valid),
        .i_second_key    (o_second_key),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // starts and ends on a falling edge
    task automatic send_note(input t_key key, input t_key vel);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        note_key <= key;
        velocity <= vel;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : note_source
        int   n;
        int   k;
        int   phrase_left;
        int   pool_base;
        int   pool_span;
        t_key key;
        t_key vel;
        phrase_left = 0;
        pool_base   = 0;
        pool_span   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes, front re-press, move, releases of absent keys and on empty stack
        send_note(7'd0, 7'd127);
        send_note(7'd127, 7'd1);
        send_note(7'd127, 7'd64);
        send_note(7'd0, 7'd85);
        send_note(7'd64, 7'd0);
        send_note(7'd0, 7'd0);
        send_note(7'd127, 7'd0);
        send_note(7'd127, 7'd0);
        // fill, overflow, move from middle and back, then releases
        for (k = 0; k < DEPTH; k++) send_note(t_key'(20 - k), t_key'(42 + k));
        send_note(7'd100, 7'd127);
        send_note(7'd17, 7'd3);
        send_note(7'd19, 7'd99);
        send_note(7'd19, 7'd0);
        send_note(7'd15, 7'd0);
        send_note(7'd18, 7'd0);
        send_note(7'd20, 7'd0);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 400 && n < 560);
            if (n == 1000) drain_results();
            if (phrase_left == 0) begin
                pool_base   = $urandom_range(0, 127);
                pool_span   = $urandom_range(3, 15);
                phrase_left = $urandom_range(10, 40);
            end
            phrase_left--;
            if ($urandom_range(0, 99) < 8) key = t_key'($urandom_range(0, 127));
            else key = t_key'(pool_base + $urandom_range(0, pool_span));
            if ($urandom_range(0, 99) < 58) vel = t_key'($urandom_range(1, 127));
            else vel = '0;
            send_note(key, vel);
        end
        no_idle = 1'b0;

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
